// ----- rtl/ctt_pkg.sv -----
// Shared types, codes and constants of the clustered transposition table.
`default_nettype none

package ctt_pkg;

  // Default geometry and register reset
  localparam int CLUSTER_COUNT_DEF = 1024;
  localparam int WAYS_DEF          = 6;
  localparam logic [14:0] MATE_RESET = 15'd32000;

  // Field widths
  localparam int IDX_W   = 10;
  localparam int KEY_W   = 32;
  localparam int DEPTH_W = 6;
  localparam int PLY_W   = 10;
  localparam int AGE_W   = 8;
  localparam int PL_W    = 48;
  localparam int ENT_W   = KEY_W + PL_W;
  localparam int RED_W   = 4;
  localparam int VAL_W   = 10;
  localparam int MATE_MARGIN = 100;

  typedef enum logic [1:0] {
    OP_PROBE  = 2'd0,
    OP_STORE  = 2'd1,
    OP_NEWSRC = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BND_EXACT = 2'd0,
    BND_LOWER = 2'd1,
    BND_UPPER = 2'd2,
    BND_NONE  = 2'd3
  } bound_t;

  typedef enum logic [3:0] {
    S_INIT_CLEAR,
    S_IDLE,
    S_CLEAR,
    S_REDUCE,
    S_BASE,
    S_READ,
    S_EVAL,
    S_WRITE,
    S_FINISH,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ready;
    logic load;
    logic reduce_step;
    logic load_base;
    logic mem_rd;
    logic eval;
    logic mem_wr;
    logic clr_step;
    logic finish;
    logic out_valid;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic reduce_done;
    logic stop;
    logic last_way;
    logic clr_last;
  } sts_t;

  // Number of conditional subtract steps that fold a cluster index
  // into the range of the cluster count.
  function automatic int reduce_steps(input int cc);
    int n;
    n = 0;
    for (int k = 0; k < IDX_W; k++) begin
      if ((longint'(cc) << k) <= longint'((1 << IDX_W) - 1)) n++;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ctt_ctrl.sv -----
// Sequencer of the clustered transposition table.
`default_nettype none

module ctt_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  input  wire                m_tready,
  input  ctt_pkg::sts_t      sts,
  output ctt_pkg::cmd_t      cmd
);

  ctt_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ctt_pkg::S_INIT_CLEAR;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ctt_pkg::S_INIT_CLEAR: if (sts.clr_last) state_next = ctt_pkg::S_IDLE;
      ctt_pkg::S_IDLE: begin
        if (s_tvalid) begin
          unique case (sts.op)
            ctt_pkg::OP_PROBE,
            ctt_pkg::OP_STORE:  state_next = ctt_pkg::S_REDUCE;
            ctt_pkg::OP_NEWSRC: state_next = ctt_pkg::S_FINISH;
            ctt_pkg::OP_CLEAR:  state_next = ctt_pkg::S_CLEAR;
            default:            state_next = ctt_pkg::S_FINISH;
          endcase
        end
      end
      ctt_pkg::S_CLEAR:  if (sts.clr_last) state_next = ctt_pkg::S_FINISH;
      ctt_pkg::S_REDUCE: if (sts.reduce_done) state_next = ctt_pkg::S_BASE;
      ctt_pkg::S_BASE:   state_next = ctt_pkg::S_READ;
      ctt_pkg::S_READ:   state_next = ctt_pkg::S_EVAL;
      ctt_pkg::S_EVAL: begin
        if (sts.stop || sts.last_way) begin
          if (sts.op == ctt_pkg::OP_STORE) state_next = ctt_pkg::S_WRITE;
          else                             state_next = ctt_pkg::S_FINISH;
        end else begin
          state_next = ctt_pkg::S_READ;
        end
      end
      ctt_pkg::S_WRITE:  state_next = ctt_pkg::S_FINISH;
      ctt_pkg::S_FINISH: state_next = ctt_pkg::S_OUT;
      ctt_pkg::S_OUT:    if (m_tready) state_next = ctt_pkg::S_IDLE;
      default:           state_next = ctt_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      ctt_pkg::S_INIT_CLEAR,
      ctt_pkg::S_CLEAR:  cmd.clr_step = 1'b1;
      ctt_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        cmd.load  = s_tvalid;
      end
      ctt_pkg::S_REDUCE: cmd.reduce_step = !sts.reduce_done;
      ctt_pkg::S_BASE:   cmd.load_base = 1'b1;
      ctt_pkg::S_READ:   cmd.mem_rd = 1'b1;
      ctt_pkg::S_EVAL:   cmd.eval = 1'b1;
      ctt_pkg::S_WRITE:  cmd.mem_wr = 1'b1;
      ctt_pkg::S_FINISH: cmd.finish = 1'b1;
      ctt_pkg::S_OUT:    cmd.out_valid = 1'b1;
      default:           cmd = '0;
    endcase
  end

  // Checks
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    cmd.out_valid |-> !cmd.ready) else $error("request taken while result pending");

  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> (state == ctt_pkg::S_INIT_CLEAR)) else $error("no clear after reset");

  a_write_after_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> $past(cmd.eval) && (sts.op == ctt_pkg::OP_STORE))
    else $error("table write without a store scan");

endmodule

`default_nettype wire

// ----- rtl/ctt_datapath.sv -----
// Datapath: entry memory, request registers, slot search and score logic.
`default_nettype none

module ctt_datapath #(
  parameter int CLUSTER_COUNT = ctt_pkg::CLUSTER_COUNT_DEF,
  parameter int WAYS          = ctt_pkg::WAYS_DEF
) (
  input  wire            clk,
  input  wire            rst,
  input  ctt_pkg::cmd_t  cmd,
  output ctt_pkg::sts_t  sts,
  input  wire  [1:0]     s_tuser,
  input  wire  [175:0]   s_tdata,
  input  wire            cfg_we,
  input  wire  [14:0]    cfg_wdata,
  output logic [1:0]     m_tuser,
  output logic [111:0]   m_tdata
);

  localparam int TOTAL  = CLUSTER_COUNT * WAYS;
  localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RED_N  = ctt_pkg::reduce_steps(CLUSTER_COUNT);

  // Request registers
  ctt_pkg::op_t                   req_op;
  logic [ctt_pkg::IDX_W-1:0]      idx;
  logic [ctt_pkg::KEY_W-1:0]      req_key;
  logic [ctt_pkg::DEPTH_W-1:0]    req_draft;
  logic [1:0]                     req_bound;
  logic signed [31:0]             req_score;
  logic [15:0]                    req_move;
  logic [ctt_pkg::PLY_W-1:0]      req_ply;
  logic signed [31:0]             req_alpha;
  logic signed [31:0]             req_beta;

  logic [ctt_pkg::AGE_W-1:0]      age;
  logic [14:0]                    mate;
  logic [ctt_pkg::RED_W-1:0]      red_cnt;
  logic [ADDR_W-1:0]              base;
  logic [WAY_W-1:0]               way;
  logic [WAY_W-1:0]               slot;
  logic [ctt_pkg::VAL_W-1:0]      best;
  logic                           best_valid;
  logic                           hit;
  logic [ctt_pkg::PL_W-1:0]       hit_pl;
  logic [ADDR_W-1:0]              clr_addr;

  logic [ctt_pkg::ENT_W-1:0]      mem [TOTAL];
  logic [ctt_pkg::ENT_W-1:0]      rdata;
  logic [ADDR_W-1:0]              waddr;
  logic [ctt_pkg::ENT_W-1:0]      wdata;
  logic                           we;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst)         mate <= ctt_pkg::MATE_RESET;
    else if (cfg_we) mate <= cfg_wdata;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= ctt_pkg::op_t'(s_tuser);
      req_key   <= s_tdata[41:10];
      req_draft <= s_tdata[47:42];
      req_bound <= s_tdata[49:48];
      req_score <= s_tdata[81:50];
      req_move  <= s_tdata[97:82];
      req_ply   <= s_tdata[107:98];
      req_alpha <= s_tdata[139:108];
      req_beta  <= s_tdata[171:140];
    end
  end

  // Search age
  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else if (cmd.load) begin
      if (ctt_pkg::op_t'(s_tuser) == ctt_pkg::OP_NEWSRC) age <= age + 1'b1;
      else if (ctt_pkg::op_t'(s_tuser) == ctt_pkg::OP_CLEAR) age <= '0;
    end
  end

  // Cluster index folding, one conditional subtract per cycle
  logic [31:0] red_thr;
  always_comb begin
    red_thr = '0;
    if (red_cnt != '0) red_thr = 32'(CLUSTER_COUNT) << (red_cnt - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx     <= s_tdata[9:0];
      red_cnt <= ctt_pkg::RED_W'(RED_N);
    end else if (cmd.reduce_step) begin
      if ({22'd0, idx} >= red_thr) idx <= idx - red_thr[ctt_pkg::IDX_W-1:0];
      red_cnt <= red_cnt - 1'b1;
    end
  end

  // Cluster base address
  always_ff @(posedge clk) begin
    if (cmd.load_base) base <= ADDR_W'(ADDR_W'(idx) * ADDR_W'(WAYS));
  end

  // Way scan evaluation
  logic [ctt_pkg::KEY_W-1:0]   e_key;
  logic [ctt_pkg::PL_W-1:0]    e_pl;
  logic [ctt_pkg::DEPTH_W-1:0] e_depth;
  logic [ctt_pkg::AGE_W-1:0]   e_diff;
  logic [ctt_pkg::VAL_W-1:0]   e_val;
  logic                        st_stop, pr_hit, stop;

  always_comb begin
    e_key   = rdata[31:0];
    e_pl    = rdata[79:32];
    e_depth = e_pl[37:32];
    e_diff  = age - e_pl[47:40];
    e_val   = ctt_pkg::VAL_W'({e_depth, 3'b000}) + ctt_pkg::VAL_W'(e_diff);
    st_stop = (e_key == req_key) || (e_key == '0);
    pr_hit  = (e_key == req_key) && (e_depth >= req_draft);
    stop    = (req_op == ctt_pkg::OP_STORE) ? st_stop : pr_hit;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      way        <= '0;
      slot       <= '0;
      best_valid <= 1'b0;
      hit        <= 1'b0;
    end else if (cmd.eval) begin
      way <= way + 1'b1;
      if (req_op == ctt_pkg::OP_STORE) begin
        if (st_stop) begin
          slot <= way;
        end else if (!best_valid || e_val < best) begin
          best       <= e_val;
          best_valid <= 1'b1;
          slot       <= way;
        end
      end else if (pr_hit) begin
        hit    <= 1'b1;
        hit_pl <= e_pl;
      end
    end
  end

  // Store score: mate shift by ply, then saturate to 16 bits
  logic signed [33:0] st_hi, st_lo, st_sc;
  logic [15:0]        st_sc16;
  always_comb begin
    st_hi = 34'(mate) - 34'(ctt_pkg::MATE_MARGIN);
    st_lo = 34'(ctt_pkg::MATE_MARGIN) - 34'(mate);
    st_sc = 34'(req_score);
    if (st_sc > st_hi)      st_sc = st_sc - 34'(req_ply);
    else if (st_sc < st_lo) st_sc = st_sc + 34'(req_ply);
    if (st_sc > 34'sd32767)       st_sc16 = 16'h7FFF;
    else if (st_sc < -34'sd32768) st_sc16 = 16'h8000;
    else                          st_sc16 = st_sc[15:0];
  end

  // Memory write source: clearing sweep or store
  always_comb begin
    we    = cmd.clr_step || cmd.mem_wr;
    waddr = cmd.clr_step ? clr_addr : ADDR_W'(base + ADDR_W'(slot));
    wdata = cmd.clr_step ? '0
          : {age, req_bound, req_draft, st_sc16, req_move, req_key};
  end

  always_ff @(posedge clk) begin
    if (rst)                clr_addr <= '0;
    else if (cmd.load)      clr_addr <= '0;
    else if (cmd.clr_step)  clr_addr <= clr_addr + 1'b1;
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.mem_rd) rdata <= mem[ADDR_W'(base + ADDR_W'(way))];
  end

  // Probe result: undo mate shift and apply the bound cutoff
  logic signed [17:0] pr_hi, pr_lo, pr_sc;
  logic signed [31:0] pr_sc32;
  logic               pr_cut;
  logic signed [31:0] pr_alpha, pr_beta;
  always_comb begin
    pr_hi    = 18'(mate) - 18'(ctt_pkg::MATE_MARGIN);
    pr_lo    = 18'(ctt_pkg::MATE_MARGIN) - 18'(mate);
    pr_sc    = 18'(signed'(hit_pl[31:16]));
    if (pr_sc > pr_hi)      pr_sc = pr_sc + 18'(req_ply);
    else if (pr_sc < pr_lo) pr_sc = pr_sc - 18'(req_ply);
    pr_sc32  = 32'(pr_sc);
    pr_cut   = 1'b0;
    pr_alpha = req_alpha;
    pr_beta  = req_beta;
    priority case (ctt_pkg::bound_t'(hit_pl[39:38]))
      ctt_pkg::BND_EXACT: begin
        pr_cut = 1'b1; pr_alpha = pr_sc32; pr_beta = pr_sc32;
      end
      ctt_pkg::BND_LOWER: if (pr_sc32 >= req_beta) begin
        pr_cut = 1'b1; pr_alpha = pr_sc32;
      end
      ctt_pkg::BND_UPPER: if (pr_sc32 <= req_alpha) begin
        pr_cut = 1'b1; pr_beta = pr_sc32;
      end
      default: pr_cut = 1'b0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (req_op == ctt_pkg::OP_PROBE && hit) begin
        m_tuser <= {1'b1, pr_cut};
        m_tdata <= {pr_beta, pr_alpha, hit_pl[15:0], pr_sc32};
      end else begin
        m_tuser <= 2'b00;
        m_tdata <= {req_beta, req_alpha, 16'd0, 32'd0};
      end
    end
  end

  // Status
  always_comb begin
    sts.op          = cmd.ready ? ctt_pkg::op_t'(s_tuser) : req_op;
    sts.reduce_done = (red_cnt == '0);
    sts.stop        = stop;
    sts.last_way    = (way == WAY_W'(WAYS - 1));
    sts.clr_last    = (clr_addr == ADDR_W'(TOTAL - 1));
  end

  // Checks
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> (slot <= WAY_W'(WAYS - 1))) else $error("store slot out of cluster");

  a_hit_only_probe: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && hit |-> (req_op == ctt_pkg::OP_PROBE)) else $error("hit outside probe");

endmodule

`default_nettype wire

// ----- rtl/clustered_transposition_table.sv -----
// Top level of the clustered transposition table.
// Probe/store: fold steps, cluster base, then a read and an evaluation per way scanned, a
// write on a store, and the result; one entry per read, 0 fold steps at 1024 clusters.
// New search: age step, then the result. Clear: CLUSTER_COUNT*WAYS entries, one a cycle.
// One request at a time; the next is taken once the result has been taken.
// After rst a pass clearing all CLUSTER_COUNT*WAYS entries runs before the first request.
`default_nettype none

module clustered_transposition_table #(
  parameter int CLUSTER_COUNT = ctt_pkg::CLUSTER_COUNT_DEF,
  parameter int WAYS          = ctt_pkg::WAYS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // cluster_index, check_key, draft, bound_kind, score_in, move_from, move_to,
  // promotion, ply_distance, alpha_in, beta_in, zero pad
  input  wire  [175:0] s_tdata,
  // operation
  input  wire  [1:0]   s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // score_out, best_from, best_to, best_promotion, alpha_out, beta_out
  output logic [111:0] m_tdata,
  // cutoff, found
  output logic [1:0]   m_tuser,
  input  wire          cfg_we,
  input  wire  [14:0]  cfg_wdata
);

  ctt_pkg::cmd_t cmd;
  ctt_pkg::sts_t sts;

  ctt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctt_datapath #(
    .CLUSTER_COUNT (CLUSTER_COUNT),
    .WAYS          (WAYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

  assign s_tready = cmd.ready;
  assign m_tvalid = cmd.out_valid;

endmodule

`default_nettype wire
